/* rtl/core/gwm_pkg.sv */
`timescale 1ns / 1ps

package gwm_pkg;

	localparam int ROW_BITS       = 5;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int COUNT_BITS     = 6;
	localparam int TOTAL_OUT_BITS = 20;
	localparam int S_DATA_BITS    = 32;
	localparam int M_DATA_BITS    = 24;

	localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 6'd32;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_SCAN,
		ST_EVAL
	} gwm_state_t;

	typedef struct packed {
		logic fire;
		logic last;
		logic store;
	} ld_ctrl_t;

	typedef struct packed {
		logic                      valid;
		logic [TOTAL_OUT_BITS-1:0] total;
	} res_t;

endpackage

/* rtl/core/greedy_weighted_matching_core.sv */
// An input transaction is taken whenever it is offered while the block is loading.
// After the last entry matching passes run, k+1 of them for k chosen edges; the result follows
// the final pass once the output register is free.
// Throughput is set by the single read port of the weight memory that each pass walks.
// After reset and after each result a clearing pass writes zero, one a cycle, into each of the
// 2**(2*ceil(log2(MAX_VERTICES))) memory words (1024 by default) with input held off.
`timescale 1ns / 1ps

module greedy_weighted_matching_core #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gwm_pkg::COUNT_BITS-1:0]     cfg_data,    // vertex_count
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gwm_pkg::S_DATA_BITS-1:0]    s_tdata,     // row_vertex, col_vertex, edge_weight
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gwm_pkg::M_DATA_BITS-1:0]    m_tdata      // matching_total
);

	import gwm_pkg::*;

	localparam int VB = $clog2(MAX_VERTICES);

	logic [COUNT_BITS-1:0]     vertex_count_q;
	logic [VB:0]               vertex_num;
	logic [ROW_BITS-1:0]       row_v, col_v;
	logic [7:0]                row_ext, col_ext;
	logic [31:0]               weight_ext;
	ld_ctrl_t                  ld;
	logic [2*VB-1:0]           ld_addr;
	logic [WEIGHT_BITS-1:0]    ld_wdata;
	logic                      out_free;
	res_t                      res;
	logic                      m_tvalid_q;
	logic [TOTAL_OUT_BITS-1:0] total_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	assign vertex_num = (32'(vertex_count_q) > MAX_VERTICES) ? (VB+1)'(MAX_VERTICES)
	                                                          : (VB+1)'(vertex_count_q);

	assign row_v      = s_tdata[4:0];
	assign col_v      = s_tdata[9:5];
	assign weight_ext = {16'b0, s_tdata[25:10]};
	assign row_ext    = {3'b0, row_v};
	assign col_ext    = {3'b0, col_v};

	assign ld.fire  = s_tvalid && s_tready;
	assign ld.last  = s_tlast;
	assign ld.store = (col_v > row_v) && (32'(col_v) < MAX_VERTICES);
	assign ld_addr  = {row_ext[VB-1:0], col_ext[VB-1:0]};
	assign ld_wdata = weight_ext[WEIGHT_BITS-1:0];

	assign out_free = !m_tvalid_q || m_tready;

	gwm_engine #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertex_num (vertex_num),
		.ld         (ld),
		.ld_addr    (ld_addr),
		.ld_wdata   (ld_wdata),
		.out_free   (out_free),
		.load_ready (s_tready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			total_q <= res.total;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_BITS-TOTAL_OUT_BITS){1'b0}}, total_q};

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result produced while the output register is occupied");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> !s_tready)
		else $error("input accepted during the clearing pass");

	a_scan_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.fire && s_tlast) |=> !s_tready)
		else $error("input accepted while matching runs");

	a_load_stays_open: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.fire && !s_tlast) |=> s_tready)
		else $error("loading stopped after an entry that was not last");

endmodule

/* rtl/core/gwm_ram.sv */
`timescale 1ns / 1ps

module gwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/gwm_engine.sv */
`timescale 1ns / 1ps

module gwm_engine #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_VERTICES):0]       vertex_num,
	input  gwm_pkg::ld_ctrl_t                   ld,
	input  logic [2*$clog2(MAX_VERTICES)-1:0]   ld_addr,
	input  logic [WEIGHT_BITS-1:0]              ld_wdata,
	input  logic                                out_free,
	output logic                                load_ready,
	output gwm_pkg::res_t                       res
);

	import gwm_pkg::*;

	localparam int VB = $clog2(MAX_VERTICES);
	localparam int AB = 2 * VB;
	localparam int TB = WEIGHT_BITS + VB;

	gwm_state_t state_q, state_next;

	logic [AB-1:0]           clr_q;
	logic [VB:0]             i_q, j_q;
	logic                    rd_s1;
	logic [VB-1:0]           ri_s1, rj_s1;
	logic [WEIGHT_BITS-1:0]  best_q;
	logic [VB-1:0]           bi_q, bj_q;
	logic [TB-1:0]           total_q;
	logic [MAX_VERTICES-1:0] used_q;

	logic                    pass_end;
	logic                    row_skip;
	logic                    ram_we, ram_re;
	logic [AB-1:0]           ram_waddr, ram_raddr;
	logic [WEIGHT_BITS-1:0]  ram_wdata, ram_rdata;
	logic                    result_fire;
	logic [TB+TOTAL_OUT_BITS-1:0] total_ext;

	assign pass_end = (i_q + 1'b1) >= vertex_num;
	assign row_skip = used_q[i_q[VB-1:0]] || (j_q >= vertex_num);
	assign total_ext = {{TOTAL_OUT_BITS{1'b0}}, total_q};

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {AB{1'b1}}) begin
					state_next = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (ld.fire && ld.last) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pass_end) begin
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (best_q != '0) begin
					state_next = ST_SCAN;
				end else if (out_free) begin
					state_next = ST_CLEAR;
				end
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = clr_q;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = {i_q[VB-1:0], j_q[VB-1:0]};
		load_ready  = 1'b0;
		result_fire = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_LOAD: begin
				load_ready = 1'b1;
				ram_we     = ld.fire && ld.store;
				ram_waddr  = ld_addr;
				ram_wdata  = ld_wdata;
			end
			ST_SCAN: begin
				ram_re = !pass_end && !row_skip && !used_q[j_q[VB-1:0]];
			end
			ST_EVAL: begin
				result_fire = (best_q == '0) && out_free;
			end
			default: ;
		endcase
	end

	assign res.valid = result_fire;
	assign res.total = total_ext[TOTAL_OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			i_q     <= '0;
			j_q     <= (VB+1)'(1);
			rd_s1   <= 1'b0;
			best_q  <= '0;
			total_q <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_next;
			rd_s1   <= ram_re;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_SCAN && !pass_end) begin
				if (row_skip) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + (VB+1)'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (rd_s1 && (ram_rdata > best_q)) begin
				best_q <= ram_rdata;
			end
			if (state_q == ST_EVAL && best_q != '0) begin
				total_q <= total_q + TB'(best_q);
				used_q  <= used_q | (MAX_VERTICES'(1) << bi_q) | (MAX_VERTICES'(1) << bj_q);
				best_q  <= '0;
				i_q     <= '0;
				j_q     <= (VB+1)'(1);
			end
			if (result_fire) begin
				total_q <= '0;
				used_q  <= '0;
				clr_q   <= '0;
				i_q     <= '0;
				j_q     <= (VB+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= i_q[VB-1:0];
		rj_s1 <= j_q[VB-1:0];
		if (rd_s1 && (ram_rdata > best_q)) begin
			bi_q <= ri_s1;
			bj_q <= rj_s1;
		end
	end

	gwm_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (1 << AB)
	) u_weight_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
